FILE: rtl/vcde_pkg.sv
`default_nettype none

package vcde_pkg;

	// cube edge length when nothing else is asked for
	localparam int SIDE_DEF = 4;

	// command codes
	typedef enum logic [3:0] {
		REQ_SET     = 4'd0,
		REQ_CLEAR   = 4'd1,
		REQ_FLIP    = 4'd2,
		REQ_READ    = 4'd3,
		REQ_PLANE   = 4'd4,
		REQ_LINE    = 4'd5,
		REQ_DIAG    = 4'd6,
		REQ_FILL    = 4'd7,
		REQ_SAVE    = 4'd8,
		REQ_RESTORE = 4'd9
	} req_t;

	// axis codes
	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic step;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic last;
	} dp_stat_t;

	// one bit per voxel that lies inside a cube of the given edge
	function automatic logic [63:0] cube_mask(input int side);
		logic [63:0] m;
		logic [5:0]  idx;
		m = '0;
		for (int i = 0; i < 64; i++) begin
			idx  = 6'(i);
			m[i] = (int'(idx[1:0]) < side) && (int'(idx[3:2]) < side) &&
				(int'(idx[5:4]) < side);
		end
		return m;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/vcde_ctrl.sv
`default_nettype none

module vcde_ctrl
	import vcde_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output dp_cmd_t  cmd,
	input  dp_stat_t stat
);

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	state_t state_q;
	logic   done_q;

	always_comb begin
		cmd.load = (state_q == ST_IDLE) && start;
		cmd.step = (state_q == ST_RUN);
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			// strobe in the cycle after the last step
			done_q <= (state_q == ST_RUN) && stat.last;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (stat.last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted command did not raise busy");
	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a command at work");
`endif

endmodule

`default_nettype wire

FILE: rtl/vcde_datapath.sv
`default_nettype none

module vcde_datapath
	import vcde_pkg::*;
#(
	parameter int SIDE = SIDE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	output dp_stat_t    stat,
	input  logic [3:0]  req_type,
	input  logic [1:0]  axis,
	input  logic [1:0]  pos_x,
	input  logic [1:0]  pos_y,
	input  logic [1:0]  pos_z,
	input  logic [1:0]  end_u,
	input  logic [1:0]  end_v,
	input  logic [1:0]  plane_index,
	input  logic        level,
	input  logic [3:0]  pattern,
	output logic        voxel_value,
	output logic [63:0] frame
);

	localparam logic [63:0] CUBE = cube_mask(SIDE);

	// latched command
	logic [3:0] req_q;
	logic [1:0] axis_q, x_q, y_q, z_q, pidx_q;
	logic       level_q;
	logic [3:0] pattern_q;

	// line walker
	logic [1:0] cur_q, hi_q;

	// diagonal walker
	logic [1:0] a_q, b_q, den_q, add_q, rem_q;
	logic [2:0] num_q;
	logic       amajor_q, sa_q, sb_q;

	// buffers and result
	logic [63:0] frame_q, saved_q;
	logic        value_q;

	// load-time values
	logic [1:0] line_start, line_lo, line_hi, da, db, den_c;
	logic       amajor_c;

	// step-time values
	logic        axis_ok;
	logic [5:0]  vox_idx, line_idx;
	logic [1:0]  lx, ly, lz;
	logic [63:0] vox_m, line_m, plane_m, diag_m, fill_m, frame_n;
	logic [2:0]  num_sum, num_n;
	logic        minor, a_inc, b_inc;
	logic [5:0]  ci;

	always_comb begin
		case (axis)
			AXIS_X:  line_start = pos_x;
			AXIS_Y:  line_start = pos_y;
			default: line_start = pos_z;
		endcase
		line_lo  = (line_start < end_u) ? line_start : end_u;
		line_hi  = (line_start < end_u) ? end_u : line_start;
		da       = (end_u >= pos_x) ? end_u - pos_x : pos_x - end_u;
		db       = (end_v >= pos_y) ? end_v - pos_y : pos_y - end_v;
		amajor_c = (da >= db);
		den_c    = amajor_c ? da : db;
	end

	always_comb begin
		axis_ok = axis_q inside {AXIS_X, AXIS_Y, AXIS_Z};
		vox_idx = {z_q, y_q, x_q};
		vox_m   = (64'd1 << vox_idx) & CUBE;

		lx = (axis_q == AXIS_X) ? cur_q : x_q;
		ly = (axis_q == AXIS_Y) ? cur_q : y_q;
		lz = (axis_q == AXIS_Z) ? cur_q : z_q;
		line_idx = {lz, ly, lx};
		line_m   = axis_ok ? ((64'd1 << line_idx) & CUBE) : '0;

		for (int i = 0; i < 64; i++) begin
			ci = 6'(i);
			case (axis_q)
				AXIS_X: begin
					plane_m[i] = (ci[1:0] == pidx_q) && CUBE[i];
					diag_m[i]  = (ci[1:0] == a_q) && (ci[5:4] == b_q) && CUBE[i];
				end
				AXIS_Y: begin
					plane_m[i] = (ci[3:2] == pidx_q) && CUBE[i];
					diag_m[i]  = (ci[5:4] == a_q) && (ci[3:2] == b_q) && CUBE[i];
				end
				AXIS_Z: begin
					plane_m[i] = (ci[5:4] == pidx_q) && CUBE[i];
					diag_m[i]  = (ci[1:0] == a_q) && (ci[3:2] == b_q) && CUBE[i];
				end
				default: begin
					plane_m[i] = 1'b0;
					diag_m[i]  = 1'b0;
				end
			endcase
			fill_m[i] = pattern_q[ci[1:0]] && CUBE[i];
		end

		// bresenham error term and next point
		num_sum = num_q + {1'b0, add_q};
		minor   = (num_sum >= {1'b0, den_q});
		num_n   = minor ? (num_sum - {1'b0, den_q}) : num_sum;
		a_inc   = amajor_q ? 1'b1 : minor;
		b_inc   = amajor_q ? minor : 1'b1;

		frame_n = frame_q;
		case (req_t'(req_q))
			REQ_SET:     frame_n = frame_q | vox_m;
			REQ_CLEAR:   frame_n = frame_q & ~vox_m;
			REQ_FLIP:    frame_n = frame_q ^ vox_m;
			REQ_PLANE:   frame_n = level_q ? (frame_q | plane_m) : (frame_q & ~plane_m);
			REQ_LINE:    frame_n = level_q ? (frame_q | line_m) : (frame_q & ~line_m);
			REQ_DIAG:    frame_n = frame_q | diag_m;
			REQ_FILL:    frame_n = fill_m;
			REQ_RESTORE: frame_n = saved_q;
			default:     frame_n = frame_q;
		endcase

		case (req_t'(req_q))
			REQ_LINE: stat.last = !axis_ok || (cur_q == hi_q);
			REQ_DIAG: stat.last = !axis_ok || (rem_q == 2'd0);
			default:  stat.last = 1'b1;
		endcase
	end

	// command latch and walkers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q     <= req_type;
			axis_q    <= axis;
			x_q       <= pos_x;
			y_q       <= pos_y;
			z_q       <= pos_z;
			pidx_q    <= plane_index;
			level_q   <= level;
			pattern_q <= pattern;
			cur_q     <= line_lo;
			hi_q      <= line_hi;
			a_q       <= pos_x;
			b_q       <= pos_y;
			sa_q      <= (end_u < pos_x);
			sb_q      <= (end_v < pos_y);
			amajor_q  <= amajor_c;
			den_q     <= den_c;
			add_q     <= amajor_c ? db : da;
			num_q     <= {2'b00, den_c[1]};
			rem_q     <= den_c;
		end else if (cmd.step) begin
			cur_q <= cur_q + 2'd1;
			num_q <= num_n;
			rem_q <= rem_q - 2'd1;
			if (a_inc) begin
				a_q <= sa_q ? a_q - 2'd1 : a_q + 2'd1;
			end
			if (b_inc) begin
				b_q <= sb_q ? b_q - 2'd1 : b_q + 2'd1;
			end
		end
	end

	// frame and spare buffers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_q <= '0;
			saved_q <= '0;
			value_q <= 1'b0;
		end else if (cmd.step) begin
			frame_q <= frame_n;
			if (req_t'(req_q) == REQ_SAVE) begin
				saved_q <= frame_q;
			end
			value_q <= (req_t'(req_q) == REQ_READ) ? (frame_q[vox_idx] & CUBE[vox_idx]) : 1'b0;
		end
	end

	assign frame       = frame_q;
	assign voxel_value = value_q;

`ifndef ASSERT_OFF
	a_frame_in_cube: assert property (@(posedge clk) disable iff (!arst_n)
		(frame_q & ~CUBE) == 64'd0)
		else $error("voxel lit outside the cube");
	a_line_in_span: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && (req_q == REQ_LINE) && axis_ok) |-> (cur_q <= hi_q))
		else $error("line walker ran past its end");
`endif

endmodule

`default_nettype wire

FILE: rtl/voxel_cube_draw_engine_unit.sv
`default_nettype none

// channel   handshake               fields
// command   start, accepted !busy   req_type axis pos_x pos_y pos_z end_u end_v
//                                   plane_index level pattern
// result    done, one-cycle strobe  voxel_value frame
//
// a command is latched at the accepting edge, then the datapath runs one step
// per cycle and the strobe follows the cycle after the last step
// single-voxel, plane, fill, save, restore and read take one step; a line takes
// one step per position (up to four), a diagonal plane one step per bresenham
// point (up to four)
// busy stays high from acceptance to the strobe cycle; in the strobe cycle a
// new command may already be taken
// reset clears both buffers (cube dark) and the controller
// the receiver cannot stall: each result is shown for one cycle only

module voxel_cube_draw_engine_unit
	import vcde_pkg::*;
#(
	parameter int SIDE = SIDE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [3:0]  req_type,
	input  logic [1:0]  axis,
	input  logic [1:0]  pos_x,
	input  logic [1:0]  pos_y,
	input  logic [1:0]  pos_z,
	input  logic [1:0]  end_u,
	input  logic [1:0]  end_v,
	input  logic [1:0]  plane_index,
	input  logic        level,
	input  logic [3:0]  pattern,
	output logic        done,
	output logic        voxel_value,
	output logic [63:0] frame
);

	// command and status between controller and datapath
	dp_cmd_t  cmd;
	dp_stat_t stat;

	// sequencer: idle, then one step per cycle until the datapath flags the last
	vcde_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	// frame buffer, spare buffer, line and bresenham walkers
	vcde_datapath #(
		.SIDE (SIDE)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req_type    (req_type),
		.axis        (axis),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.end_u       (end_u),
		.end_v       (end_v),
		.plane_index (plane_index),
		.level       (level),
		.pattern     (pattern),
		.voxel_value (voxel_value),
		.frame       (frame)
	);

endmodule

`default_nettype wire

FILE: verif/cube_frame_checker.sv
`timescale 1ns / 100ps

module cube_frame_checker
	import vcde_pkg::*;
#(
	parameter int SIDE = SIDE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [3:0]  req_type,
	input  logic [1:0]  axis,
	input  logic [1:0]  pos_x,
	input  logic [1:0]  pos_y,
	input  logic [1:0]  pos_z,
	input  logic [1:0]  end_u,
	input  logic [1:0]  end_v,
	input  logic [1:0]  plane_index,
	input  logic        level,
	input  logic [3:0]  pattern,
	input  logic        done,
	input  logic        voxel_value,
	input  logic [63:0] frame,
	output int          fail_count,
	output int          pending
);

	typedef struct {
		logic        voxel;
		logic [63:0] cube;
	} frame_beat_t;

	logic [3:0]  cube_rows [16];
	logic [3:0]  spare_rows [16];
	frame_beat_t frames_due [$];
	int          mismatches;

	assign fail_count = mismatches;

	function automatic bit in_cube(input int x, input int y, input int z);
		return x >= 0 && y >= 0 && z >= 0 && x < SIDE && y < SIDE && z < SIDE;
	endfunction

	function automatic void paint(input int x, input int y, input int z, input bit on);
		if (in_cube(x, y, z)) begin
			cube_rows[(z * 4 + y) & 15][x] = on;
		end
	endfunction

	// bresenham over (a,b), each point extruded along the free axis (z for anchor Z, y for X, x for Y)
	function automatic void paint_diagonal(input logic [1:0] anchor, input int a1,
		input int b1, input int a2, input int b2);
		int da, db, sa, sb, a, b, den, acc, rise;
		bit a_major;
		da = (a2 >= a1) ? a2 - a1 : a1 - a2;
		db = (b2 >= b1) ? b2 - b1 : b1 - b2;
		sa = (a2 >= a1) ? 1 : -1;
		sb = (b2 >= b1) ? 1 : -1;
		a = a1;
		b = b1;
		a_major = da >= db;
		den = a_major ? da : db;
		rise = a_major ? db : da;
		acc = den / 2;
		if (anchor > AXIS_Z) return;
		for (int n = 0; n <= den; n++) begin
			for (int k = 0; k < SIDE; k++) begin
				if (anchor == AXIS_Z) paint(a, b, k, 1'b1);
				else if (anchor == AXIS_X) paint(a, k, b, 1'b1);
				else paint(k, b, a, 1'b1);
			end
			acc += rise;
			if (acc >= den) begin
				acc -= den;
				if (a_major) b += sb;
				else a += sa;
			end
			if (a_major) a += sa;
			else b += sb;
		end
	endfunction

	// applies one command to the shadow cube and returns what the block should show
	function automatic frame_beat_t apply_draw_cmd();
		frame_beat_t r;
		int lo, hi, first;
		r.voxel = 1'b0;
		r.cube  = '0;
		case (req_type)
			REQ_SET: paint(pos_x, pos_y, pos_z, 1'b1);
			REQ_CLEAR: paint(pos_x, pos_y, pos_z, 1'b0);
			REQ_FLIP: begin
				if (in_cube(pos_x, pos_y, pos_z))
					cube_rows[(pos_z * 4 + pos_y) & 15][pos_x] =
						~cube_rows[(pos_z * 4 + pos_y) & 15][pos_x];
			end
			REQ_READ: begin
				if (in_cube(pos_x, pos_y, pos_z))
					r.voxel = cube_rows[(pos_z * 4 + pos_y) & 15][pos_x];
			end
			REQ_PLANE: begin
				for (int a = 0; a < SIDE; a++)
					for (int b = 0; b < SIDE; b++) begin
						if (axis == AXIS_X) paint(plane_index, a, b, level);
						else if (axis == AXIS_Y) paint(a, plane_index, b, level);
						else if (axis == AXIS_Z) paint(a, b, plane_index, level);
					end
			end
			REQ_LINE: begin
				first = (axis == AXIS_X) ? pos_x : (axis == AXIS_Y) ? pos_y : pos_z;
				lo = (first < end_u) ? first : end_u;
				hi = (first < end_u) ? end_u : first;
				if (axis <= AXIS_Z) begin
					for (int i = lo; i <= hi; i++) begin
						if (axis == AXIS_X) paint(i, pos_y, pos_z, level);
						else if (axis == AXIS_Y) paint(pos_x, i, pos_z, level);
						else paint(pos_x, pos_y, i, level);
					end
				end
			end
			REQ_DIAG: paint_diagonal(axis, pos_x, pos_y, end_u, end_v);
			REQ_FILL: begin
				for (int z = 0; z < SIDE; z++)
					for (int y = 0; y < SIDE; y++)
						for (int x = 0; x < 4; x++)
							cube_rows[(z * 4 + y) & 15][x] = (x < SIDE) ? pattern[x] : 1'b0;
			end
			REQ_SAVE: spare_rows = cube_rows;
			REQ_RESTORE: cube_rows = spare_rows;
			default: ;
		endcase
		for (int row = 0; row < 16; row++) r.cube[4 * row +: 4] = cube_rows[row];
		return r;
	endfunction

	task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
		$display("%0t mismatch on %s: expected %h, got %h", $realtime, what, want, got);
		mismatches++;
	endtask

	initial mismatches = 0;

	always @(posedge clk or negedge arst_n) begin
		frame_beat_t seen, want;
		if (!arst_n) begin
			foreach (cube_rows[i]) begin
				cube_rows[i]  = '0;
				spare_rows[i] = '0;
			end
			frames_due.delete();
			pending <= 0;
		end else begin
			// the strobe of the older command is retired before a new beat is queued
			if (done === 1'b1) begin
				if (frames_due.size() == 0) begin
					report("unexpected result", 64'd0, frame);
				end else begin
					want = frames_due.pop_front();
					seen.voxel = voxel_value;
					seen.cube  = frame;
					if (seen.voxel !== want.voxel) report("voxel_value", want.voxel, seen.voxel);
					if (seen.cube !== want.cube) report("frame", want.cube, seen.cube);
				end
			end
			if (start === 1'b1 && busy === 1'b0) frames_due.push_back(apply_draw_cmd());
			pending <= frames_due.size();
		end
	end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;
	import vcde_pkg::*;

	// codes the block must treat as no-ops
	localparam logic [1:0] AXIS_NONE  = 2'd3;
	localparam logic [3:0] REQ_SPARE  = 4'd15;
	localparam int         RAND_BEATS = 850;
	// last stretch runs back to back with no idling
	localparam int         CALM_TAIL  = 100;
	// midway the sender drains the block completely
	localparam int         DRAIN_AT   = 400;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [3:0]  req_type;
	logic [1:0]  axis;
	logic [1:0]  pos_x;
	logic [1:0]  pos_y;
	logic [1:0]  pos_z;
	logic [1:0]  end_u;
	logic [1:0]  end_v;
	logic [1:0]  plane_index;
	logic        level;
	logic [3:0]  pattern;
	logic        done;
	logic        voxel_value;
	logic [63:0] frame;
	int          fail_count;
	int          pending;

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	voxel_cube_draw_engine_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.axis        (axis),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.end_u       (end_u),
		.end_v       (end_v),
		.plane_index (plane_index),
		.level       (level),
		.pattern     (pattern),
		.done        (done),
		.voxel_value (voxel_value),
		.frame       (frame)
	);

	// watches both channels, keeps the shadow cube and counts mismatches
	cube_frame_checker i_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.req_type    (req_type),
		.axis        (axis),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.end_u       (end_u),
		.end_v       (end_v),
		.plane_index (plane_index),
		.level       (level),
		.pattern     (pattern),
		.done        (done),
		.voxel_value (voxel_value),
		.frame       (frame),
		.fail_count  (fail_count),
		.pending     (pending)
	);

	// present one command beat and hold it until the block takes it
	// start is left high so a following beat can go out back to back
	task automatic send_cmd(input logic [3:0] rq, input logic [1:0] ax, input logic [1:0] x,
		input logic [1:0] y, input logic [1:0] z, input logic [1:0] eu, input logic [1:0] ev,
		input logic [1:0] pidx, input logic lv, input logic [3:0] pat);
		start       <= 1'b1;
		req_type    <= rq;
		axis        <= ax;
		pos_x       <= x;
		pos_y       <= y;
		pos_z       <= z;
		end_u       <= eu;
		end_v       <= ev;
		plane_index <= pidx;
		level       <= lv;
		pattern     <= pat;
		do @(posedge clk); while (busy !== 1'b0);
	endtask

	// drop start and scribble on the fields; nothing should be latched meanwhile
	task automatic go_quiet();
		start       <= 1'b0;
		req_type    <= 4'($urandom);
		axis        <= 2'($urandom);
		pos_x       <= 2'($urandom);
		pos_y       <= 2'($urandom);
		pos_z       <= 2'($urandom);
		end_u       <= 2'($urandom);
		end_v       <= 2'($urandom);
		plane_index <= 2'($urandom);
		level       <= 1'($urandom);
		pattern     <= 4'($urandom);
	endtask

	// random command with mostly legal codes, a sprinkle of spare codes and axis three
	task automatic send_random_cmd();
		logic [3:0] rq;
		logic [1:0] ax;
		rq = ($urandom_range(0, 99) < 6) ? 4'($urandom_range(10, 15)) : 4'($urandom_range(0, 9));
		ax = ($urandom_range(0, 9) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
		send_cmd(rq, ax, 2'($urandom), 2'($urandom), 2'($urandom), 2'($urandom),
			2'($urandom), 2'($urandom), 1'($urandom), 4'($urandom));
	endtask

	// wait for the block to hand back every beat it owes
	task automatic drain();
		do @(posedge clk); while (pending != 0);
	endtask

	initial begin
		arst_n      = 1'b0;
		start       = 1'b0;
		req_type    = '0;
		axis        = '0;
		pos_x       = '0;
		pos_y       = '0;
		pos_z       = '0;
		end_u       = '0;
		end_v       = '0;
		plane_index = '0;
		level       = 1'b0;
		pattern     = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corners, every command, both line orders, steep and shallow diagonals
		send_cmd(REQ_READ,    AXIS_X, 2'd3, 2'd3, 2'd3, 2'd0, 2'd0, 2'd0, 1'b0, 4'h0);
		send_cmd(REQ_SET,     AXIS_X, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 4'h0);
		send_cmd(REQ_SET,     AXIS_X, 2'd3, 2'd3, 2'd3, 2'd0, 2'd0, 2'd0, 1'b0, 4'h0);
		send_cmd(REQ_READ,    AXIS_X, 2'd3, 2'd3, 2'd3, 2'd0, 2'd0, 2'd0, 1'b0, 4'h0);
		send_cmd(REQ_FLIP,    AXIS_X, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 4'h0);
		send_cmd(REQ_FLIP,    AXIS_X, 2'd2, 2'd1, 2'd3, 2'd0, 2'd0, 2'd0, 1'b0, 4'h0);
		send_cmd(REQ_CLEAR,   AXIS_X, 2'd3, 2'd3, 2'd3, 2'd0, 2'd0, 2'd0, 1'b0, 4'h0);
		send_cmd(REQ_PLANE,   AXIS_X, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd3, 1'b1, 4'h0);
		send_cmd(REQ_PLANE,   AXIS_Y, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 1'b1, 4'h0);
		send_cmd(REQ_PLANE,   AXIS_Z, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd3, 1'b0, 4'h0);
		send_cmd(REQ_SAVE,    AXIS_X, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 4'h0);
		send_cmd(REQ_FILL,    AXIS_X, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 4'h0);
		send_cmd(REQ_LINE,    AXIS_X, 2'd3, 2'd1, 2'd2, 2'd0, 2'd0, 2'd0, 1'b1, 4'h0);
		send_cmd(REQ_LINE,    AXIS_Y, 2'd1, 2'd0, 2'd3, 2'd3, 2'd0, 2'd0, 1'b1, 4'h0);
		send_cmd(REQ_LINE,    AXIS_Z, 2'd2, 2'd2, 2'd2, 2'd2, 2'd0, 2'd0, 1'b1, 4'h0);
		send_cmd(REQ_DIAG,    AXIS_Z, 2'd0, 2'd0, 2'd3, 2'd1, 2'd0, 2'd0, 1'b0, 4'h0);
		send_cmd(REQ_DIAG,    AXIS_X, 2'd3, 2'd3, 2'd1, 2'd0, 2'd0, 2'd0, 1'b0, 4'h0);
		send_cmd(REQ_DIAG,    AXIS_Y, 2'd2, 2'd0, 2'd2, 2'd3, 2'd0, 2'd0, 1'b0, 4'h0);
		send_cmd(REQ_FILL,    AXIS_X, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 4'hF);
		send_cmd(REQ_LINE,    AXIS_X, 2'd0, 2'd2, 2'd1, 2'd3, 2'd0, 2'd0, 1'b0, 4'h0);
		send_cmd(REQ_PLANE,   AXIS_NONE, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd1, 1'b0, 4'h0);
		send_cmd(REQ_LINE,    AXIS_NONE, 2'd0, 2'd0, 2'd0, 2'd3, 2'd0, 2'd0, 1'b0, 4'h0);
		send_cmd(REQ_DIAG,    AXIS_NONE, 2'd0, 2'd0, 2'd3, 2'd3, 2'd0, 2'd0, 1'b0, 4'h0);
		send_cmd(REQ_SPARE,   AXIS_X, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 2'd3, 1'b1, 4'hF);
		send_cmd(REQ_RESTORE, AXIS_X, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 2'd0, 1'b0, 4'h0);

		// random traffic with idle bursts between some beats, none in the tail
		for (int i = 0; i < RAND_BEATS; i++) begin
			send_random_cmd();
			if (i == DRAIN_AT) begin
				go_quiet();
				drain();
			end else if (i < RAND_BEATS - CALM_TAIL && $urandom_range(0, 3) == 0) begin
				go_quiet();
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
		end
		go_quiet();

		// let the last beat come home, then allow time for anything stray
		drain();
		repeat (10) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
